[hdl/aitb_pkg.sv]
// Shared types and codes for the interleaved-to-planar corner-turn buffer.
// No dependencies; imported by aitb_seq and the top level.
package aitb_pkg;

   localparam int SAMPLE_W = 32;
   localparam int CODE_W   = 3;
   localparam int INDEX_W  = 1;

   // request kinds carried on req_tuser
   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_READ = 1'b1;

   // register indexes
   localparam logic [INDEX_W-1:0] REG_CONVERSION = 1'd0;
   localparam logic [INDEX_W-1:0] REG_BLOCK_SRC  = 1'd1;

   // conversion codes
   localparam logic [CODE_W-1:0] CONV_FIRST  = 3'd1;
   localparam logic [CODE_W-1:0] CONV_MID_A  = 3'd2;
   localparam logic [CODE_W-1:0] CONV_MID_B  = 3'd3;
   localparam logic [CODE_W-1:0] CONV_LAST   = 3'd4;
   localparam logic [CODE_W-1:0] CONV_RESET  = CONV_FIRST;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_CODE = 2'd1,
      STATUS_NOT_FULL = 2'd2
   } status_type;

   // sequencer view of the current request, passed to the top level
   typedef struct packed {
      status_type status;
      logic       last;
      logic       rd_en;
      logic       wr_en;
   } seq_info_type;

endpackage

[hdl/aitb_store.sv]
// Sample store: single-clock RAM, one write and one read port, registered read.
// No package dependencies.
module aitb_store #(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9,
   parameter int DATA_W = 32
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read data holds until the next read, so it doubles as output storage
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hdl/aitb_seq.sv]
// Address sequencer: load and emit counters, frame state, straight and
// transposed read addresses. Depends on aitb_pkg.
module aitb_seq #(
   parameter int SPC      = 256,
   parameter int IN_CH    = 2,
   parameter int FRAME_IN = 512,
   parameter int FRAME_OUT = 512,
   parameter int ADDR_W   = 9
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      load_req,
   input  logic                      read_req,
   input  logic [aitb_pkg::CODE_W-1:0] conv_code,
   input  logic                      block_src,
   output logic [ADDR_W-1:0]         wr_addr,
   output logic [ADDR_W-1:0]         rd_addr,
   output aitb_pkg::seq_info_type    info
);
   import aitb_pkg::*;

   localparam int SW = (SPC > 1) ? $clog2(SPC) : 1;
   localparam int CW = (IN_CH > 1) ? $clog2(IN_CH) : 1;
   localparam int LW = $clog2(FRAME_IN + 1);
   localparam int EW = (FRAME_OUT > 1) ? $clog2(FRAME_OUT) : 1;

   logic [LW-1:0]     load_cnt_ff, load_cnt_in;
   logic              full_ff, full_in;
   logic [EW-1:0]     emit_cnt_ff, emit_cnt_in;
   logic [ADDR_W-1:0] pos_ff, pos_in;     // straight position ch*SPC + s
   logic [ADDR_W-1:0] tpos_ff, tpos_in;   // transposed address s*IN_CH + ch
   logic [SW-1:0]     s_ff, s_in;
   logic [CW-1:0]     ch_ff, ch_in;

   logic       code_ok;
   logic       transpose;
   logic       last;
   status_type status;
   logic       wr_en;
   logic       rd_en;

   always_comb begin
      code_ok   = (conv_code >= CONV_FIRST) && (conv_code <= CONV_LAST);
      transpose = ((conv_code == CONV_MID_A) || (conv_code == CONV_MID_B)) != !block_src;
      if (!code_ok) begin
         status = STATUS_BAD_CODE;
      end else if (!full_ff) begin
         status = STATUS_NOT_FULL;
      end else begin
         status = STATUS_OK;
      end
      last  = (emit_cnt_ff == EW'(FRAME_OUT - 1));
      wr_en = load_req && !full_ff;
      rd_en = read_req && (status == STATUS_OK);
   end

   assign wr_addr = load_cnt_ff[ADDR_W-1:0];
   assign rd_addr = transpose ? tpos_ff : pos_ff;

   always_comb begin
      info.status = status;
      info.last   = last;
      info.rd_en  = rd_en;
      info.wr_en  = wr_en;
   end

   always_comb begin
      load_cnt_in = load_cnt_ff;
      full_in     = full_ff;
      emit_cnt_in = emit_cnt_ff;
      pos_in      = pos_ff;
      tpos_in     = tpos_ff;
      s_in        = s_ff;
      ch_in       = ch_ff;
      if (wr_en) begin
         load_cnt_in = load_cnt_ff + LW'(1);
         if (load_cnt_ff == LW'(FRAME_IN - 1)) begin
            full_in = 1'b1;
         end
      end
      if (rd_en) begin
         if (last) begin
            load_cnt_in = '0;
            full_in     = 1'b0;
            emit_cnt_in = '0;
            pos_in      = '0;
            tpos_in     = '0;
            s_in        = '0;
            ch_in       = '0;
         end else begin
            emit_cnt_in = emit_cnt_ff + EW'(1);
            if (s_ff == SW'(SPC - 1)) begin
               s_in = '0;
               if (ch_ff == CW'(IN_CH - 1)) begin
                  // output wraps around the stored frame
                  ch_in   = '0;
                  pos_in  = '0;
                  tpos_in = '0;
               end else begin
                  ch_in   = ch_ff + CW'(1);
                  pos_in  = pos_ff + ADDR_W'(1);
                  tpos_in = ADDR_W'(ch_ff) + ADDR_W'(1);
               end
            end else begin
               s_in    = s_ff + SW'(1);
               pos_in  = pos_ff + ADDR_W'(1);
               tpos_in = tpos_ff + ADDR_W'(IN_CH);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff <= '0;
         full_ff     <= 1'b0;
         emit_cnt_ff <= '0;
         pos_ff      <= '0;
         tpos_ff     <= '0;
         s_ff        <= '0;
         ch_ff       <= '0;
      end else begin
         load_cnt_ff <= load_cnt_in;
         full_ff     <= full_in;
         emit_cnt_ff <= emit_cnt_in;
         pos_ff      <= pos_in;
         tpos_ff     <= tpos_in;
         s_ff        <= s_in;
         ch_ff       <= ch_in;
      end
   end

endmodule

[hdl/audio_interleave_transpose_buffer_core.sv]
// Corner-turn buffer top level: handshakes, config registers, response register.
// A read request's response is registered and is valid in the cycle after the request is taken.
// Throughput: 1 word per cycle while rsp_tready is high; the store sees at most one
// access per word (a write for a load that fits, a registered read for an ok read).
// Reset (synchronous): counters and frame state cleared, conversion_code = 1,
// file_type_is_one = 1. The sample store is not cleared and needs no clearing pass.
module audio_interleave_transpose_buffer_core #(
   parameter int SAMPLES_PER_CHANNEL = 256,
   parameter int IN_CHANNELS         = 2,
   parameter int OUT_CHANNELS        = 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [aitb_pkg::SAMPLE_W-1:0] req_tdata,   // [31:0] in_sample
   input  logic                          req_tuser,   // [0] op
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [aitb_pkg::SAMPLE_W-1:0] rsp_tdata,   // [31:0] out_sample
   output logic                          rsp_tlast,
   output logic [1:0]                    rsp_tuser,   // [1:0] status
   input  logic                          csr_we,
   input  logic [aitb_pkg::INDEX_W-1:0]  csr_index,
   input  logic [aitb_pkg::CODE_W-1:0]   csr_wdata
);
   import aitb_pkg::*;

   localparam int FRAME_IN  = SAMPLES_PER_CHANNEL * IN_CHANNELS;
   localparam int FRAME_OUT = SAMPLES_PER_CHANNEL * OUT_CHANNELS;
   localparam int ADDR_W    = (FRAME_IN > 1) ? $clog2(FRAME_IN) : 1;

   logic [CODE_W-1:0]   conv_ff, conv_in;
   logic                ftype_ff, ftype_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic                rsp_last_ff, rsp_last_in;

   logic                req_take;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ADDR_W-1:0]   rd_addr;
   logic [SAMPLE_W-1:0] rd_data;
   seq_info_type        info;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_take   = req_tvalid && req_tready;

   aitb_seq #(
      .SPC       (SAMPLES_PER_CHANNEL),
      .IN_CH     (IN_CHANNELS),
      .FRAME_IN  (FRAME_IN),
      .FRAME_OUT (FRAME_OUT),
      .ADDR_W    (ADDR_W)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .load_req  (req_take && (req_tuser == OP_LOAD)),
      .read_req  (req_take && (req_tuser == OP_READ)),
      .conv_code (conv_ff),
      .block_src (ftype_ff),
      .wr_addr   (wr_addr),
      .rd_addr   (rd_addr),
      .info      (info)
   );

   aitb_store #(
      .DEPTH  (FRAME_IN),
      .ADDR_W (ADDR_W),
      .DATA_W (SAMPLE_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (info.wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_tdata),
      .rd_en   (info.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      conv_in  = conv_ff;
      ftype_in = ftype_ff;
      if (csr_we) begin
         case (csr_index)
            REG_CONVERSION: conv_in  = csr_wdata;
            REG_BLOCK_SRC:  ftype_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;
      if (req_take && (req_tuser == OP_READ)) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = info.status;
         rsp_last_in   = (info.status == STATUS_OK) && info.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         conv_ff      <= CONV_RESET;
         ftype_ff     <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         conv_ff      <= conv_in;
         ftype_ff     <= ftype_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = (rsp_status_ff == STATUS_OK) ? rd_data : '0;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_status_ff;

   // a new response word only follows a taken read request
   a_rsp_from_read: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_take && (req_tuser == OP_READ)))
      else $error("response without read request");

   // error responses carry no sample and no frame end
   a_err_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff != STATUS_OK)) |-> (rsp_tdata == '0 && !rsp_tlast))
      else $error("error response carries data");

   // the store is never written and read in the same cycle
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      info.rd_en |-> !info.wr_en)
      else $error("store read and write overlap");

   // a store read is issued only for an ok read request, and a response follows
   a_read_resp: assert property (@(posedge clock) disable iff (reset)
      info.rd_en |=> (rsp_valid_ff && (rsp_status_ff == STATUS_OK)))
      else $error("store read without ok response");

endmodule

[verif/tb.sv]
// Self-checking bench for the audio corner-turn buffer: loads frames of samples, reads
// them back straight or transposed, and checks every output word against a local model.
// Depends on hdl/aitb_pkg.sv and hdl/audio_interleave_transpose_buffer_core.sv.
`timescale 1ns / 100ps

module tb;
   import aitb_pkg::*;

   localparam int SPC          = 256;
   localparam int IN_CH        = 2;
   localparam int OUT_CH       = 2;
   localparam int FRAME_IN     = SPC * IN_CH;
   localparam int FRAME_OUT    = SPC * OUT_CH;
   localparam int RANDOM_ITEMS = 1100;
   localparam int QUIET_AFTER  = 950;
   localparam int HOLD_CYCLES  = 300;

   localparam logic [CODE_W-1:0] CODE_ZERO = 3'd0;
   localparam logic [CODE_W-1:0] CODE_TOP  = 3'd7;

   typedef struct {
      logic                op;
      logic [SAMPLE_W-1:0] sample;
   } audio_req_type;

   typedef struct {
      logic [SAMPLE_W-1:0] sample;
      logic                last;
      status_type          status;
   } audio_out_type;

   logic                clock;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [SAMPLE_W-1:0] req_tdata  = '0;
   logic                req_tuser  = OP_LOAD;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [SAMPLE_W-1:0] rsp_tdata;
   logic                rsp_tlast;
   logic [1:0]          rsp_tuser;
   logic                csr_we     = 1'b0;
   logic [INDEX_W-1:0]  csr_index  = REG_CONVERSION;
   logic [CODE_W-1:0]   csr_wdata  = CONV_RESET;

   audio_interleave_transpose_buffer_core #(
      .SAMPLES_PER_CHANNEL(SPC),
      .IN_CHANNELS        (IN_CH),
      .OUT_CHANNELS       (OUT_CH)
   ) u_top (.*);

   // model state
   logic [SAMPLE_W-1:0] frame_mem [FRAME_IN];
   int unsigned         frame_loaded;
   bit                  frame_is_full;
   int unsigned         frame_emitted;
   logic [CODE_W-1:0]   cfg_code;
   logic                cfg_block_file;

   audio_req_type  sample_reqs[$];
   audio_out_type  owed_outputs[$];
   audio_req_type  cur_req;
   int unsigned words_queued, words_taken;
   int unsigned errors;
   int unsigned n_ok, n_bad_code, n_not_full, n_frames, n_transposed, n_dropped;

   bit          src_idle_on, snk_idle_on, hold_arm;
   int unsigned src_gap, snk_gap, hold_left;
   bit          hold_used;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("tb: FAIL");
      $finish;
   end

   function automatic bit code_ok(input logic [CODE_W-1:0] c);
      return c >= CONV_FIRST && c <= CONV_LAST;
   endfunction

   task automatic flag_mismatch(input string what);
      $display("tb: mismatch at %0t ns: %s", $time, what);
      errors++;
   endtask

   // one accepted request through the corner-turn model
   task automatic corner_turn_step(input audio_req_type w);
      audio_out_type o;
      int unsigned   pos, idx;
      bit            flip;
      o = '{sample: '0, last: 1'b0, status: STATUS_OK};
      if (w.op == OP_LOAD) begin
         if (frame_is_full) begin
            n_dropped++;
         end else begin
            frame_mem[frame_loaded] = w.sample;
            frame_loaded++;
            if (frame_loaded >= FRAME_IN) frame_is_full = 1'b1;
         end
      end else begin
         if (!code_ok(cfg_code)) begin
            o.status = STATUS_BAD_CODE;
            n_bad_code++;
         end else if (!frame_is_full) begin
            o.status = STATUS_NOT_FULL;
            n_not_full++;
         end else begin
            pos  = frame_emitted % FRAME_IN;
            // mid codes flip the sense for non-block source files
            flip = (cfg_code == CONV_MID_A || cfg_code == CONV_MID_B) != (cfg_block_file == 1'b0);
            idx  = flip ? (pos % SPC) * IN_CH + pos / SPC : pos;
            if (flip) n_transposed++;
            o.sample = frame_mem[idx];
            o.last   = (frame_emitted + 1 >= FRAME_OUT);
            n_ok++;
            if (o.last) begin
               frame_emitted = 0;
               frame_loaded  = 0;
               frame_is_full = 1'b0;
               n_frames++;
            end else begin
               frame_emitted++;
            end
         end
         owed_outputs.push_back(o);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         src_gap    <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            corner_turn_step(cur_req);
            words_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (src_gap > 0) begin
               src_gap    <= src_gap - 1;
               req_tvalid <= 1'b0;
            end else if (sample_reqs.size() > 0) begin
               cur_req = sample_reqs.pop_front();
               req_tdata  <= cur_req.sample;
               req_tuser  <= cur_req.op;
               req_tvalid <= 1'b1;
               if (src_idle_on && $urandom_range(0, 7) == 0)
                  src_gap <= $urandom_range(1, 19);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response ready, including the one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         snk_gap    <= 0;
         hold_left  <= 0;
         hold_used  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_arm && !hold_used) begin
         hold_used  <= 1'b1;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (snk_gap > 0) begin
         snk_gap    <= snk_gap - 1;
         rsp_tready <= 1'b0;
      end else if (snk_idle_on && $urandom_range(0, 9) == 0) begin
         snk_gap    <= $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // response checker
   always @(posedge clock) begin
      audio_out_type exp_w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (owed_outputs.size() == 0) begin
            flag_mismatch($sformatf("unexpected word data=%h last=%b status=%0d",
                                    rsp_tdata, rsp_tlast, rsp_tuser));
         end else begin
            exp_w = owed_outputs.pop_front();
            if (rsp_tuser !== exp_w.status)
               flag_mismatch($sformatf("status %0d, want %0d", rsp_tuser, exp_w.status));
            if (rsp_tdata !== exp_w.sample)
               flag_mismatch($sformatf("sample %h, want %h", rsp_tdata, exp_w.sample));
            if (rsp_tlast !== exp_w.last)
               flag_mismatch($sformatf("last %b, want %b", rsp_tlast, exp_w.last));
         end
      end
   end

   task automatic queue_word(input logic op, input logic [SAMPLE_W-1:0] s);
      sample_reqs.push_back('{op: op, sample: s});
      words_queued++;
   endtask

   // every word taken, every response back, then let the pipe settle
   task automatic wait_drained();
      while (words_taken != words_queued || owed_outputs.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [CODE_W-1:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      if (idx == REG_CONVERSION) cfg_code = val;
      else cfg_block_file = val[0];
   endtask

   initial begin : stimulus
      int unsigned       n, i, counted, frames_seen, loaded_p, emitted_p;
      bit                full_p, valid_now, bad_full_done;
      logic              op;
      logic [CODE_W-1:0] code;

      frame_loaded   = 0;
      frame_is_full  = 1'b0;
      frame_emitted  = 0;
      cfg_code       = CONV_RESET;
      cfg_block_file = 1'b1;
      src_idle_on    = 1'b1;
      snk_idle_on    = 1'b1;
      hold_arm       = 1'b0;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reads before the frame is full, field extremes, bad codes
      queue_word(OP_READ, 32'hFFFF_FFFF);
      queue_word(OP_LOAD, 32'h8000_0000);
      queue_word(OP_LOAD, 32'h7FFF_FFFF);
      queue_word(OP_LOAD, 32'h0000_0000);
      queue_word(OP_LOAD, 32'hFFFF_FFFF);
      queue_word(OP_READ, 32'h0000_0000);
      wait_drained();
      write_reg(REG_CONVERSION, CODE_ZERO);
      queue_word(OP_READ, 32'h1234_5678);
      queue_word(OP_LOAD, 32'hAAAA_AAAA);
      wait_drained();
      write_reg(REG_CONVERSION, CODE_TOP);
      queue_word(OP_READ, 32'h0);
      wait_drained();
      write_reg(REG_CONVERSION, CONV_LAST + 3'd1);
      queue_word(OP_READ, 32'h0);
      wait_drained();
      write_reg(REG_CONVERSION, CONV_LAST + 3'd2);
      queue_word(OP_READ, 32'h0);
      wait_drained();
      write_reg(REG_CONVERSION, CONV_LAST);
      write_reg(REG_BLOCK_SRC, 3'b110);
      queue_word(OP_READ, 32'h0);
      queue_word(OP_LOAD, 32'h5555_5555);
      wait_drained();

      // random phases: mostly well-formed frames, some noise, config between phases
      counted       = 0;
      frames_seen   = 0;
      bad_full_done = 1'b0;
      while (counted < RANDOM_ITEMS || frames_seen == 0) begin
         if (counted >= QUIET_AFTER) begin
            src_idle_on = 1'b0;
            snk_idle_on = 1'b0;
         end else begin
            src_idle_on = ($urandom_range(0, 3) != 0);
            snk_idle_on = ($urandom_range(0, 3) != 0);
         end
         if (frame_is_full && !bad_full_done) begin
            code          = CODE_TOP;
            bad_full_done = 1'b1;
         end else if ($urandom_range(0, 5) == 0) begin
            code = ($urandom_range(0, 3) == 0) ? CODE_ZERO
                                               : CODE_W'(CONV_LAST + $urandom_range(1, 3));
         end else begin
            code = CODE_W'($urandom_range(CONV_FIRST, CONV_LAST));
         end
         if (code != cfg_code || $urandom_range(0, 1) == 0)
            write_reg(REG_CONVERSION, code);
         if ($urandom_range(0, 1) == 0)
            write_reg(REG_BLOCK_SRC, CODE_W'($urandom_range(0, 7)));

         valid_now = code_ok(cfg_code);
         n = valid_now ? $urandom_range(20, 120) : $urandom_range(4, 12);
         // stall the output long enough that the input backs up
         if (valid_now && frame_is_full && !hold_arm) begin
            hold_arm = 1'b1;
            n        = 150;
         end

         loaded_p  = frame_loaded;
         full_p    = frame_is_full;
         emitted_p = frame_emitted;
         for (i = 0; i < n; i++) begin
            if (full_p) op = ($urandom_range(0, 19) == 0) ? OP_LOAD : OP_READ;
            else        op = ($urandom_range(0, 19) == 0) ? OP_READ : OP_LOAD;
            queue_word(op, $urandom());
            if (op == OP_LOAD) begin
               if (!full_p) begin
                  counted++;
                  loaded_p++;
                  if (loaded_p >= FRAME_IN) full_p = 1'b1;
               end
            end else begin
               counted++;
               if (valid_now && full_p) begin
                  emitted_p++;
                  if (emitted_p >= FRAME_OUT) begin
                     emitted_p = 0;
                     loaded_p  = 0;
                     full_p    = 1'b0;
                     frames_seen++;
                  end
               end
            end
         end
         wait_drained();
      end

      repeat (20) @(posedge clock);
      $display("tb: %0d requests, %0d frames read out, %0d good words (%0d transposed)",
               words_taken, n_frames, n_ok, n_transposed);
      $display("tb: %0d bad-code reads, %0d early reads, %0d loads dropped on a full frame",
               n_bad_code, n_not_full, n_dropped);
      if (errors == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
